// ----- rtl/triangle_face_normal_unit_defines.svh -----
// Assertion macros for the triangle face normal unit checkers.
`ifndef TRIANGLE_FACE_NORMAL_UNIT_DEFINES_SVH
`define TRIANGLE_FACE_NORMAL_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TFN_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define TFN_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/tfn_pkg.sv -----
// Types and constants shared by the triangle face normal unit.
`default_nettype none
package tfn_pkg;
  localparam int CW  = 16;                  // vertex coordinate width
  localparam int FB  = 14;                  // fraction bits of the normal
  localparam int OW  = FB + 2;              // normal component width
  localparam int EW  = CW + 1;              // edge width
  localparam int PW  = 2 * EW;              // edge product width
  localparam int XW  = PW + 1;              // cross term width, signed
  localparam int MW  = XW - 1;              // cross term magnitude width
  localparam int SQW = 2 * MW;              // squared magnitude width
  localparam int SW  = SQW + 2;             // squared length width
  localparam int RW  = 2 * (FB + 2) + SW + 2; // remainder width, signed
  localparam int QW  = FB + 1;              // quotient width

  typedef struct packed {
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic signed [CW-1:0] az;
    logic signed [CW-1:0] bx;
    logic signed [CW-1:0] by_coord;
    logic signed [CW-1:0] bz;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [CW-1:0] cz;
  } in_word_t;

  typedef struct packed {
    logic signed [OW-1:0] nx;
    logic signed [OW-1:0] ny;
    logic signed [OW-1:0] nz;
    logic                 degenerate;
  } out_word_t;

  typedef struct packed {
    logic [RW-1:0] rem;   // 4^(F+1) c^2 - (2q)^2 S
    logic [RW-1:0] qs;    // 2q S
    logic [QW-1:0] q;
  } lane_t;

  typedef struct packed {
    logic          valid;
    logic [SW-1:0] s;
    logic [2:0]    neg;
    lane_t [2:0]   lanes;
  } stage_t;
endpackage
`default_nettype wire

// ----- rtl/tfn_root_step.sv -----
// One bit of the rounded unit-length quotient for all three components.
`default_nettype none
module tfn_root_step #(
  parameter int BIT = 0
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire tfn_pkg::stage_t d,
  output tfn_pkg::stage_t      q
);
  localparam int RW = tfn_pkg::RW;
  localparam int SW = tfn_pkg::SW;
  localparam int QW = tfn_pkg::QW;

  tfn_pkg::stage_t q_next;
  logic [RW-1:0]   s_ext;

  assign s_ext = {{(RW-SW){1'b0}}, d.s};

  always_comb begin
    logic [RW-1:0] term;
    logic [RW-1:0] diff;
    q_next = d;
    for (int i = 0; i < 3; i++) begin
      // (2q + 2^(BIT+1) - 1)^2 S - (2q)^2 S
      term = (d.lanes[i].qs << (BIT + 2)) - (d.lanes[i].qs << 1)
           + (s_ext << (2 * BIT + 2)) - (s_ext << (BIT + 2)) + s_ext;
      diff = d.lanes[i].rem - term;
      if (!diff[RW-1]) begin
        q_next.lanes[i].rem = d.lanes[i].rem - (d.lanes[i].qs << (BIT + 2))
                            - (s_ext << (2 * BIT + 2));
        q_next.lanes[i].qs  = d.lanes[i].qs + (s_ext << (BIT + 1));
        q_next.lanes[i].q   = d.lanes[i].q | (QW'(1) << BIT);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q <= q_next;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/triangle_face_normal_unit.sv -----
// Top level of the triangle face normal unit.
// Takes one triangle per cycle and returns its unit face normal in signed Q1.14,
// each component rounded to nearest, ties away from zero; a zero cross product
// gives a zero vector with degenerate set. The pipeline registers are edges,
// products, cross terms, squares, squared length, fifteen quotient bit stages
// and the output register. Throughput is one word per cycle; the whole pipeline
// holds while a finished word waits at the output.
`default_nettype none
module triangle_face_normal_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire tfn_pkg::in_word_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output tfn_pkg::out_word_t      out_data
);
  localparam int FB  = tfn_pkg::FB;
  localparam int OW  = tfn_pkg::OW;
  localparam int EW  = tfn_pkg::EW;
  localparam int PW  = tfn_pkg::PW;
  localparam int XW  = tfn_pkg::XW;
  localparam int MW  = tfn_pkg::MW;
  localparam int SQW = tfn_pkg::SQW;
  localparam int SW  = tfn_pkg::SW;
  localparam int RW  = tfn_pkg::RW;

  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // edges
  logic                 v1;
  logic signed [EW-1:0] e1x, e1y, e1z, e2x, e2y, e2z;
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1  <= in_valid;
      e1x <= EW'(in_data.bx) - EW'(in_data.ax);
      e1y <= EW'(in_data.by_coord) - EW'(in_data.ay);
      e1z <= EW'(in_data.bz) - EW'(in_data.az);
      e2x <= EW'(in_data.cx) - EW'(in_data.ax);
      e2y <= EW'(in_data.cy) - EW'(in_data.ay);
      e2z <= EW'(in_data.cz) - EW'(in_data.az);
    end
  end

  // products
  logic                 v2;
  logic signed [PW-1:0] p [6];
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2   <= v1;
      p[0] <= e1y * e2z;
      p[1] <= e1z * e2y;
      p[2] <= e1z * e2x;
      p[3] <= e1x * e2z;
      p[4] <= e1x * e2y;
      p[5] <= e1y * e2x;
    end
  end

  // cross terms as sign and magnitude
  logic                 v3;
  logic [MW-1:0]        mag [3];
  logic [2:0]           neg3;
  logic signed [XW-1:0] cr [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cr[i] = XW'(p[2*i]) - XW'(p[2*i+1]);
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
      for (int i = 0; i < 3; i++) begin
        neg3[i] <= cr[i][XW-1];
        mag[i]  <= cr[i][XW-1] ? MW'(-cr[i]) : MW'(cr[i]);
      end
    end
  end

  // squares
  logic           v4;
  logic [SQW-1:0] sq [3];
  logic [2:0]     neg4;
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4   <= v3;
      neg4 <= neg3;
      for (int i = 0; i < 3; i++) begin
        sq[i] <= mag[i] * mag[i];
      end
    end
  end

  // squared length and remainder seeds
  tfn_pkg::stage_t st [FB+2];
  always_ff @(posedge clk) begin
    if (rst) begin
      st[0].valid <= 1'b0;
    end else if (en) begin
      st[0].valid <= v4;
      st[0].neg   <= neg4;
      st[0].s     <= SW'(sq[0]) + SW'(sq[1]) + SW'(sq[2]);
      for (int i = 0; i < 3; i++) begin
        st[0].lanes[i].rem <= RW'(sq[i]) << (2 * FB + 2);
        st[0].lanes[i].qs  <= '0;
        st[0].lanes[i].q   <= '0;
      end
    end
  end

  for (genvar k = 0; k <= FB; k++) begin : g_step
    tfn_root_step #(.BIT(FB - k)) u_step (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .d   (st[k]),
      .q   (st[k+1])
    );
  end

  // sign and degenerate handling
  tfn_pkg::stage_t    fin;
  tfn_pkg::out_word_t res;
  logic               deg;
  logic [OW-1:0]      comp [3];
  assign fin = st[FB+1];
  assign deg = (fin.s == '0);
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      comp[i] = deg ? '0 :
                fin.neg[i] ? OW'(-{1'b0, fin.lanes[i].q}) : OW'({1'b0, fin.lanes[i].q});
    end
    res.nx         = comp[0];
    res.ny         = comp[1];
    res.nz         = comp[2];
    res.degenerate = deg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= fin.valid;
      out_data  <= res;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/tfn_checker.sv -----
// Port-level checks for the triangle face normal unit, bound to the top level.
`default_nettype none
`include "triangle_face_normal_unit_defines.svh"
module tfn_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire tfn_pkg::out_word_t out_data
);
  `TFN_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)
  `TFN_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && out_stall, $stable(out_data))
  `TFN_ASSERT_NOW(a_stall_cause, clk, rst, in_stall, out_valid && out_stall)
  `TFN_ASSERT_NOW(a_degen_zero, clk, rst, out_valid && out_data.degenerate,
    out_data.nx == '0 && out_data.ny == '0 && out_data.nz == '0)
  `TFN_ASSERT_NEXT(a_in_hold, clk, rst, in_valid && in_stall, in_valid)
endmodule

bind triangle_face_normal_unit tfn_checker u_tfn_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
